>>> rtl/lfit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfit_pkg
// Types, constants and codes shared by the lowest free index table.
// ----------------------------------------------------------------------------
package lfit_pkg;

	// table geometry
	localparam int DEPTH     = 1024;
	localparam int LAST_SLOT = (DEPTH - 1 < 1023) ? DEPTH - 1 : 1023;
	localparam int SLOT_W    = 10;
	localparam int HDL_W     = 32;
	localparam int SLOT_AW   = $clog2(DEPTH);

	// bitmaps are kept as rows of ROW_W bits
	localparam int ROW_W  = 32;
	localparam int BIT_AW = $clog2(ROW_W);
	localparam int ROWS   = DEPTH / ROW_W;
	localparam int ROW_AW = $clog2(ROWS);

	localparam logic [SLOT_W-1:0] RESERVED_TOP_RESET = SLOT_W'(2);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET    = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_CONFLICT  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ASUM,
		S_AROW,
		S_RD,
		S_EVAL,
		S_TSUM,
		S_TROW,
		S_PUSH
	} state_t;

	// request to the shared bit search unit
	typedef struct packed {
		logic [ROW_W-1:0] vec;
		logic             highest;
	} pick_req_t;

	// answer of the shared bit search unit
	typedef struct packed {
		logic              any;
		logic [BIT_AW-1:0] pos;
	} pick_rsp_t;

endpackage

>>> rtl/lfit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfit_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfit_ram #(
	parameter int AW = 10,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lfit_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfit_pick
// Shared bit search unit: position of the lowest or highest set bit of a row.
// ----------------------------------------------------------------------------
module lfit_pick (
	input  lfit_pkg::pick_req_t req,
	output lfit_pkg::pick_rsp_t rsp
);

	logic [lfit_pkg::ROW_W-1:0]  vec_r;
	logic [lfit_pkg::ROW_W-1:0]  low_1h;
	logic [lfit_pkg::BIT_AW-1:0] pos_r;

	// mirror the row for a highest-bit search
	always_comb begin
		for (int j = 0; j < lfit_pkg::ROW_W; j++) begin
			vec_r[j] = req.highest ? req.vec[lfit_pkg::ROW_W-1-j] : req.vec[j];
		end
	end

	// isolate the lowest set bit
	assign low_1h = vec_r & (~vec_r + lfit_pkg::ROW_W'(1));

	// one-hot to binary
	always_comb begin
		pos_r = '0;
		for (int j = 0; j < lfit_pkg::ROW_W; j++) begin
			if (low_1h[j]) begin
				pos_r = pos_r | lfit_pkg::BIT_AW'(j);
			end
		end
	end

	assign rsp.any = |req.vec;
	assign rsp.pos = req.highest ? ~pos_r : pos_r;

endmodule

>>> rtl/lowest_free_index_table_top.sv
`timescale 1ns / 1ps
// Steps: get and set go through read, evaluate and hand-off; add first searches the free marks
//   (or grows past high water, or goes straight to hand-off when full); a good remove trims the tail.
// Throughput: one item at a time; the next item is taken once the result is registered.
// The sequencer steps, the registered RAM reads and the shared bit search set the timing of an item.
// Reset: no clearing pass; row valid and summary bits clear at once, so the block
//   takes items right after reset. high_water resets to 2 and reloads on a config write.
// ----------------------------------------------------------------------------
// lowest_free_index_table_top
// Index allocator table: add, remove, get and set on 1024 slots of handles.
// ----------------------------------------------------------------------------
module lowest_free_index_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfit_pkg::SLOT_W-1:0]   cfg_data,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [lfit_pkg::SLOT_W-1:0]   slot_index,
	input  logic [lfit_pkg::HDL_W-1:0]    handle_in,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lfit_pkg::SLOT_W-1:0]   slot_out,
	output logic [lfit_pkg::HDL_W-1:0]    handle_out,
	output logic                          found,
	output logic [1:0]                    status
);

	lfit_pkg::state_t state_q, state_d;

	// control state
	logic                          out_valid_q, out_valid_d;
	logic [lfit_pkg::SLOT_W-1:0]   hw_q, hw_d;
	logic [lfit_pkg::ROWS-1:0]     occ_vld_q, occ_vld_d;
	logic [lfit_pkg::ROWS-1:0]     free_sum_q, free_sum_d;

	// item and result registers
	lfit_pkg::op_t                 op_q, op_d;
	logic [lfit_pkg::SLOT_W-1:0]   tgt_q, tgt_d;
	logic [lfit_pkg::HDL_W-1:0]    hdl_q, hdl_d;
	logic [lfit_pkg::ROW_AW-1:0]   row_q, row_d;
	logic [lfit_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
	logic [lfit_pkg::HDL_W-1:0]    res_hdl_q, res_hdl_d;
	logic                          res_fnd_q, res_fnd_d;
	lfit_pkg::status_t             res_st_q, res_st_d;
	logic [lfit_pkg::SLOT_W-1:0]   slot_out_q, slot_out_d;
	logic [lfit_pkg::HDL_W-1:0]    hdl_out_q, hdl_out_d;
	logic                          fnd_out_q, fnd_out_d;
	lfit_pkg::status_t             st_out_q, st_out_d;

	// memory ports
	logic                          hdl_we;
	logic [lfit_pkg::HDL_W-1:0]    hdl_rdata;
	logic                          occ_we;
	logic [lfit_pkg::ROW_W-1:0]    occ_wdata, occ_rdata;
	logic                          free_we;
	logic [lfit_pkg::ROW_AW-1:0]   free_waddr, free_raddr;
	logic [lfit_pkg::ROW_W-1:0]    free_wdata, free_rdata;

	lfit_pkg::pick_req_t           pick_req;
	lfit_pkg::pick_rsp_t           pick_rsp;

	logic [lfit_pkg::ROW_AW-1:0]   row_sel;
	logic [lfit_pkg::BIT_AW-1:0]   bit_sel;
	logic [lfit_pkg::ROW_W-1:0]    occ_row, free_row, row_clr;
	logic                          occ_hit, in_range;
	logic [lfit_pkg::SLOT_W-1:0]   top_slot;

	// slot under work split into row and bit
	assign row_sel  = tgt_q[lfit_pkg::SLOT_AW-1:lfit_pkg::BIT_AW];
	assign bit_sel  = tgt_q[lfit_pkg::BIT_AW-1:0];
	assign in_range = tgt_q <= lfit_pkg::SLOT_W'(lfit_pkg::LAST_SLOT);

	// rows that are not valid read as empty
	assign occ_row  = occ_vld_q[row_sel] ? occ_rdata : '0;
	assign free_row = free_sum_q[row_sel] ? free_rdata : '0;
	assign occ_hit  = occ_row[bit_sel];

	// searched row with the found bit cleared
	assign row_clr  = free_rdata & ~(lfit_pkg::ROW_W'(1) << pick_rsp.pos);
	assign top_slot = lfit_pkg::SLOT_W'({row_q, pick_rsp.pos});

	// shared search unit: summary first, then the chosen row
	always_comb begin
		pick_req.highest = (state_q == lfit_pkg::S_TSUM) || (state_q == lfit_pkg::S_TROW);
		if ((state_q == lfit_pkg::S_ASUM) || (state_q == lfit_pkg::S_TSUM)) begin
			pick_req.vec = lfit_pkg::ROW_W'(free_sum_q);
		end else begin
			pick_req.vec = free_rdata;
		end
	end

	lfit_pick u_pick (
		.req (pick_req),
		.rsp (pick_rsp)
	);

	// free mark row read address
	always_comb begin
		if ((state_q == lfit_pkg::S_ASUM) || (state_q == lfit_pkg::S_TSUM)) begin
			free_raddr = lfit_pkg::ROW_AW'(pick_rsp.pos);
		end else begin
			free_raddr = row_sel;
		end
	end

	lfit_ram #(.AW(lfit_pkg::SLOT_AW), .DW(lfit_pkg::HDL_W)) u_hdl_ram (
		.clk   (clk),
		.we    (hdl_we),
		.waddr (tgt_q[lfit_pkg::SLOT_AW-1:0]),
		.wdata (hdl_q),
		.raddr (tgt_q[lfit_pkg::SLOT_AW-1:0]),
		.rdata (hdl_rdata)
	);

	lfit_ram #(.AW(lfit_pkg::ROW_AW), .DW(lfit_pkg::ROW_W)) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr (row_sel),
		.wdata (occ_wdata),
		.raddr (row_sel),
		.rdata (occ_rdata)
	);

	lfit_ram #(.AW(lfit_pkg::ROW_AW), .DW(lfit_pkg::ROW_W)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	// sequencer: next state, memory writes and register updates
	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		hw_d        = hw_q;
		occ_vld_d   = occ_vld_q;
		free_sum_d  = free_sum_q;
		op_d        = op_q;
		tgt_d       = tgt_q;
		hdl_d       = hdl_q;
		row_d       = row_q;
		res_slot_d  = res_slot_q;
		res_hdl_d   = res_hdl_q;
		res_fnd_d   = res_fnd_q;
		res_st_d    = res_st_q;
		slot_out_d  = slot_out_q;
		hdl_out_d   = hdl_out_q;
		fnd_out_d   = fnd_out_q;
		st_out_d    = st_out_q;
		in_ready    = 1'b0;
		hdl_we      = 1'b0;
		occ_we      = 1'b0;
		occ_wdata   = occ_row;
		free_we     = 1'b0;
		free_waddr  = row_sel;
		free_wdata  = free_row;

		// result register drains independently
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		// configuration reloads the high-water mark
		if (cfg_valid) begin
			hw_d = cfg_data;
		end

		unique case (state_q)
			lfit_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d  = lfit_pkg::op_t'(operation);
					tgt_d = slot_index;
					hdl_d = handle_in;
					if (lfit_pkg::op_t'(operation) == lfit_pkg::OP_ADD) begin
						state_d = lfit_pkg::S_ASUM;
					end else begin
						state_d = lfit_pkg::S_RD;
					end
				end
			end

			// add: lowest row holding a free mark, or grow past high water, or report full
			lfit_pkg::S_ASUM: begin
				if (pick_rsp.any) begin
					row_d   = lfit_pkg::ROW_AW'(pick_rsp.pos);
					state_d = lfit_pkg::S_AROW;
				end else if (hw_q >= lfit_pkg::SLOT_W'(lfit_pkg::LAST_SLOT)) begin
					res_slot_d = '0;
					res_hdl_d  = '0;
					res_fnd_d  = 1'b0;
					res_st_d   = lfit_pkg::ST_FULL;
					state_d    = lfit_pkg::S_PUSH;
				end else begin
					hw_d    = hw_q + lfit_pkg::SLOT_W'(1);
					tgt_d   = hw_q + lfit_pkg::SLOT_W'(1);
					state_d = lfit_pkg::S_RD;
				end
			end

			// add: lowest bit of that row, consume its mark
			lfit_pkg::S_AROW: begin
				tgt_d             = top_slot;
				free_we           = 1'b1;
				free_waddr        = row_q;
				free_wdata        = row_clr;
				free_sum_d[row_q] = |row_clr;
				state_d           = lfit_pkg::S_RD;
			end

			lfit_pkg::S_RD: begin
				state_d = lfit_pkg::S_EVAL;
			end

			lfit_pkg::S_EVAL: begin
				state_d    = lfit_pkg::S_PUSH;
				res_slot_d = tgt_q;
				res_hdl_d  = '0;
				res_fnd_d  = 1'b0;
				res_st_d   = lfit_pkg::ST_OK;
				case (op_q)
					lfit_pkg::OP_ADD: begin
						if (occ_hit) begin
							res_hdl_d = hdl_rdata;
							res_fnd_d = 1'b1;
							res_st_d  = lfit_pkg::ST_CONFLICT;
						end else begin
							occ_we             = 1'b1;
							occ_wdata          = occ_row | (lfit_pkg::ROW_W'(1) << bit_sel);
							occ_vld_d[row_sel] = 1'b1;
							hdl_we             = 1'b1;
						end
					end
					lfit_pkg::OP_REMOVE: begin
						if (!in_range || !occ_hit) begin
							res_st_d = lfit_pkg::ST_NOT_FOUND;
						end else begin
							occ_we              = 1'b1;
							occ_wdata           = occ_row & ~(lfit_pkg::ROW_W'(1) << bit_sel);
							free_we             = 1'b1;
							free_wdata          = free_row | (lfit_pkg::ROW_W'(1) << bit_sel);
							free_sum_d[row_sel] = 1'b1;
							res_hdl_d           = hdl_rdata;
							res_fnd_d           = 1'b1;
							state_d             = lfit_pkg::S_TSUM;
						end
					end
					lfit_pkg::OP_GET: begin
						if (in_range && occ_hit) begin
							res_hdl_d = hdl_rdata;
							res_fnd_d = 1'b1;
						end
					end
					default: begin
						// set
						if (in_range) begin
							occ_we             = 1'b1;
							occ_wdata          = occ_row | (lfit_pkg::ROW_W'(1) << bit_sel);
							occ_vld_d[row_sel] = 1'b1;
							hdl_we             = 1'b1;
							if (occ_hit) begin
								res_hdl_d = hdl_rdata;
								res_fnd_d = 1'b1;
							end
						end
					end
				endcase
			end

			// trim: highest row holding a free mark
			lfit_pkg::S_TSUM: begin
				if (pick_rsp.any) begin
					row_d   = lfit_pkg::ROW_AW'(pick_rsp.pos);
					state_d = lfit_pkg::S_TROW;
				end else begin
					state_d = lfit_pkg::S_PUSH;
				end
			end

			// trim: drop the top mark while it sits at high water
			lfit_pkg::S_TROW: begin
				if (top_slot != hw_q) begin
					state_d = lfit_pkg::S_PUSH;
				end else begin
					free_we           = 1'b1;
					free_waddr        = row_q;
					free_wdata        = row_clr;
					free_sum_d[row_q] = |row_clr;
					if (hw_q == '0) begin
						state_d = lfit_pkg::S_PUSH;
					end else begin
						hw_d    = hw_q - lfit_pkg::SLOT_W'(1);
						state_d = lfit_pkg::S_TSUM;
					end
				end
			end

			// hand the result to the output register once it is free
			lfit_pkg::S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					slot_out_d  = res_slot_q;
					hdl_out_d   = res_hdl_q;
					fnd_out_d   = res_fnd_q;
					st_out_d    = res_st_q;
					state_d     = lfit_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = lfit_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfit_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			hw_q        <= lfit_pkg::RESERVED_TOP_RESET;
			occ_vld_q   <= '0;
			free_sum_q  <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			hw_q        <= hw_d;
			occ_vld_q   <= occ_vld_d;
			free_sum_q  <= free_sum_d;
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		tgt_q      <= tgt_d;
		hdl_q      <= hdl_d;
		row_q      <= row_d;
		res_slot_q <= res_slot_d;
		res_hdl_q  <= res_hdl_d;
		res_fnd_q  <= res_fnd_d;
		res_st_q   <= res_st_d;
		slot_out_q <= slot_out_d;
		hdl_out_q  <= hdl_out_d;
		fnd_out_q  <= fnd_out_d;
		st_out_q   <= st_out_d;
	end

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign slot_out   = slot_out_q;
	assign handle_out = hdl_out_q;
	assign found      = fnd_out_q;
	assign status     = st_out_q;

	// summary says the row holds a mark, so the row search must hit
	a_arow_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfit_pkg::S_AROW) |-> pick_rsp.any)
		else $error("add row search found no free mark");

	a_trow_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lfit_pkg::S_TROW) |-> pick_rsp.any)
		else $error("trim row search found no free mark");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item taken while another is in work");

	// a result appears only from the hand-off state
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == lfit_pkg::S_PUSH))
		else $error("result raised outside hand-off");

endmodule

>>> sim/tb_lowest_free_index_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_index_table_top
// Self-checking bench for the lowest free index table. A scoreboard keeps its
// own copy of the slot table, free marks and high water counter, and predicts
// one result per accepted request. Directed requests hit the allocation corner
// cases first. Randomized requests then run under several reserved_top
// settings while both handshake sides idle at varying rates.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic [lfit_pkg::SLOT_W-1:0] slot;
	logic [lfit_pkg::HDL_W-1:0]  hdl;
	logic                        fnd;
	lfit_pkg::status_t           st;
} slot_result_t;

// predicts table behavior and compares results in order
class slot_table_scoreboard;
	bit                         occupied [lfit_pkg::DEPTH];
	bit [lfit_pkg::HDL_W-1:0]   handles  [lfit_pkg::DEPTH];
	bit                         free_mark[lfit_pkg::DEPTH];
	int unsigned                high_water;
	slot_result_t               expected_results[$];
	int                         errors;

	function new();
		for (int i = 0; i < lfit_pkg::DEPTH; i++) begin
			occupied[i]  = 1'b0;
			handles[i]   = '0;
			free_mark[i] = 1'b0;
		end
		high_water = lfit_pkg::RESERVED_TOP_RESET;
		errors     = 0;
	endfunction

	function void load_reserved_top(logic [lfit_pkg::SLOT_W-1:0] value);
		high_water = value;
	endfunction

	// lower high water over marked indices, only when the top mark sits on it
	function void trim_top();
		int top;
		top = -1;
		for (int i = lfit_pkg::LAST_SLOT; i >= 0; i--) begin
			if (free_mark[i]) begin
				top = i;
				break;
			end
		end
		if (top < 0 || top != int'(high_water))
			return;
		while (high_water <= lfit_pkg::LAST_SLOT && free_mark[high_water]) begin
			free_mark[high_water] = 1'b0;
			if (high_water == 0)
				break;
			high_water--;
		end
	endfunction

	function void note_request(lfit_pkg::op_t op, logic [lfit_pkg::SLOT_W-1:0] idx,
			logic [lfit_pkg::HDL_W-1:0] hdl);
		slot_result_t res;
		int           pick;
		bit           in_range;
		in_range = (idx <= lfit_pkg::LAST_SLOT);
		res      = '{slot: idx, hdl: '0, fnd: 1'b0, st: lfit_pkg::ST_OK};
		case (op)
			lfit_pkg::OP_ADD: begin
				pick = -1;
				for (int i = 0; i <= lfit_pkg::LAST_SLOT; i++) begin
					if (free_mark[i]) begin
						pick = i;
						break;
					end
				end
				if (pick >= 0) begin
					free_mark[pick] = 1'b0;
				end else if (high_water >= lfit_pkg::LAST_SLOT) begin
					res = '{slot: '0, hdl: '0, fnd: 1'b0, st: lfit_pkg::ST_FULL};
				end else begin
					high_water++;
					pick = int'(high_water);
				end
				if (pick >= 0) begin
					res.slot = lfit_pkg::SLOT_W'(pick);
					if (occupied[pick]) begin
						res.hdl = handles[pick];
						res.fnd = 1'b1;
						res.st  = lfit_pkg::ST_CONFLICT;
					end else begin
						occupied[pick] = 1'b1;
						handles[pick]  = hdl;
					end
				end
			end
			lfit_pkg::OP_REMOVE: begin
				if (!in_range || !occupied[idx]) begin
					res.st = lfit_pkg::ST_NOT_FOUND;
				end else begin
					res.hdl        = handles[idx];
					res.fnd        = 1'b1;
					occupied[idx]  = 1'b0;
					handles[idx]   = '0;
					free_mark[idx] = 1'b1;
					trim_top();
				end
			end
			lfit_pkg::OP_GET: begin
				if (in_range && occupied[idx]) begin
					res.hdl = handles[idx];
					res.fnd = 1'b1;
				end
			end
			default: begin
				// set: out of range is ignored, the free mark is left alone
				if (in_range) begin
					if (occupied[idx]) begin
						res.hdl = handles[idx];
						res.fnd = 1'b1;
					end
					occupied[idx] = 1'b1;
					handles[idx]  = hdl;
				end
			end
		endcase
		expected_results.push_back(res);
	endfunction

	task report(string what, logic [lfit_pkg::HDL_W-1:0] got,
			logic [lfit_pkg::HDL_W-1:0] want);
		$display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
		errors++;
	endtask

	task check_result(logic [lfit_pkg::SLOT_W-1:0] slot, logic [lfit_pkg::HDL_W-1:0] hdl,
			logic fnd, logic [1:0] st);
		slot_result_t want;
		if (expected_results.size() == 0) begin
			report("unexpected result slot", slot, '0);
			return;
		end
		want = expected_results.pop_front();
		if (slot !== want.slot) report("slot_out", slot, want.slot);
		if (hdl !== want.hdl)   report("handle_out", hdl, want.hdl);
		if (fnd !== want.fnd)   report("found", fnd, want.fnd);
		if (st !== want.st)     report("status", st, want.st);
	endtask
endclass

module tb_lowest_free_index_table_top;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_valid  = 1'b0;
	logic                        cfg_ready;
	logic [lfit_pkg::SLOT_W-1:0] cfg_data   = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_ready;
	logic [1:0]                  operation  = lfit_pkg::OP_GET;
	logic [lfit_pkg::SLOT_W-1:0] slot_index = '0;
	logic [lfit_pkg::HDL_W-1:0]  handle_in  = '0;
	logic                        out_valid;
	logic                        out_ready  = 1'b0;
	logic [lfit_pkg::SLOT_W-1:0] slot_out;
	logic [lfit_pkg::HDL_W-1:0]  handle_out;
	logic                        found;
	logic [1:0]                  status;

	localparam int PHASE_ITEMS = 340;
	localparam int TOTAL_ITEMS = 26 + 5 * PHASE_ITEMS;

	slot_table_scoreboard chk = new();
	int in_gap_pct    = 22;
	int out_stall_pct = 60;
	int sent          = 0;

	lowest_free_index_table_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.slot_index (slot_index),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot_out   (slot_out),
		.handle_out (handle_out),
		.found      (found),
		.status     (status)
	);

	// clock
	always #6 clk = ~clk;

	// result side: random stalls, check every accepted item
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			chk.check_result(slot_out, handle_out, found, status);
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// run limit
	initial begin
		#5_000_000;
		$display("tb_lowest_free_index_table_top failed");
		$finish;
	end

	// idling schedule over the run: sender light and receiver heavy, then swapped, then none
	function automatic void update_idling();
		if (sent < TOTAL_ITEMS / 3) begin
			in_gap_pct    = 22;
			out_stall_pct = 60;
		end else if (sent < 2 * TOTAL_ITEMS / 3) begin
			in_gap_pct    = 60;
			out_stall_pct = 22;
		end else begin
			in_gap_pct    = 0;
			out_stall_pct = 0;
		end
	endfunction

	// offer one request and wait for it to be taken
	task automatic send_request(lfit_pkg::op_t op, logic [lfit_pkg::SLOT_W-1:0] idx,
			logic [lfit_pkg::HDL_W-1:0] hdl);
		if ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < in_gap_pct)
				@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		slot_index <= idx;
		handle_in  <= hdl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chk.note_request(op, idx, hdl);
		sent++;
		update_idling();
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (chk.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reserved_top(logic [lfit_pkg::SLOT_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		chk.load_reserved_top(value);
	endtask

	// mostly indices near the allocated range, sometimes anywhere
	function automatic logic [lfit_pkg::SLOT_W-1:0] choose_slot();
		int unsigned span;
		span = chk.high_water + 2;
		if (span > lfit_pkg::LAST_SLOT)
			span = lfit_pkg::LAST_SLOT;
		if ($urandom_range(9) == 0)
			return lfit_pkg::SLOT_W'($urandom_range(lfit_pkg::LAST_SLOT));
		return lfit_pkg::SLOT_W'($urandom_range(span));
	endfunction

	task automatic random_phase(logic [lfit_pkg::SLOT_W-1:0] top_value);
		int unsigned   r;
		lfit_pkg::op_t op;
		write_reserved_top(top_value);
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			r = $urandom_range(99);
			if (r < 35)      op = lfit_pkg::OP_ADD;
			else if (r < 70) op = lfit_pkg::OP_REMOVE;
			else if (r < 85) op = lfit_pkg::OP_GET;
			else             op = lfit_pkg::OP_SET;
			send_request(op, choose_slot(), $urandom);
			// occasional full drain before the next item
			if (n == PHASE_ITEMS / 2 || $urandom_range(199) == 0)
				drain_results();
		end
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, fresh allocation above the reserved range
		send_request(lfit_pkg::OP_GET,    10'd0,    32'h0);
		send_request(lfit_pkg::OP_REMOVE, 10'd5,    32'h0);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h0000_0000);
		send_request(lfit_pkg::OP_ADD,    10'h3FF,  32'hFFFF_FFFF);
		// set ahead of allocation, then add runs into it
		send_request(lfit_pkg::OP_SET,    10'd5,    32'hA5A5_A5A5);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h0000_0001);
		send_request(lfit_pkg::OP_SET,    10'd4,    32'h5A5A_5A5A);
		send_request(lfit_pkg::OP_GET,    10'd4,    32'h0);
		// set on a freed index keeps its mark, add then conflicts
		send_request(lfit_pkg::OP_REMOVE, 10'd3,    32'h0);
		send_request(lfit_pkg::OP_SET,    10'd3,    32'h0000_FFFF);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h0000_0002);
		// removing the top trims down through marked indices
		send_request(lfit_pkg::OP_REMOVE, 10'd4,    32'h0);
		send_request(lfit_pkg::OP_REMOVE, 10'd5,    32'h0);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h1234_5678);
		// mark above high water blocks the trim until taken
		send_request(lfit_pkg::OP_SET,    10'd1023, 32'h8000_0001);
		send_request(lfit_pkg::OP_REMOVE, 10'd1023, 32'h0);
		send_request(lfit_pkg::OP_REMOVE, 10'd4,    32'h0);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'hDEAD_BEEF);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'hCAFE_F00D);
		send_request(lfit_pkg::OP_SET,    10'd2,    32'hFFFF_0000);

		// trim stops at index zero
		write_reserved_top(10'd0);
		send_request(lfit_pkg::OP_SET,    10'd0,    32'h0000_0007);
		send_request(lfit_pkg::OP_REMOVE, 10'd0,    32'h0);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h0F0F_0F0F);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'hF0F0_F0F0);

		// table full at the top
		write_reserved_top(10'd1023);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h1111_1111);
		write_reserved_top(10'd1022);
		send_request(lfit_pkg::OP_ADD,    10'd0,    32'h2222_2222);

		random_phase(10'd2);
		random_phase(10'd1015);
		random_phase(10'd0);
		random_phase(lfit_pkg::SLOT_W'($urandom_range(lfit_pkg::LAST_SLOT)));
		random_phase(10'd1023);

		drain_results();
		repeat (20) @(posedge clk);
		if (chk.errors == 0 && chk.expected_results.size() == 0) begin
			$display("tb_lowest_free_index_table_top passed");
		end else begin
			$display("tb_lowest_free_index_table_top failed");
		end
		$finish;
	end

endmodule
